[rtl/core/dpam_pkg.sv]
// Shared types and constants of the dual tank pressure monitor.
package dpam_pkg;

    // Field widths
    localparam int SAMPLE_W = 10;
    localparam int Q_W      = 13;
    localparam int QUOT_W   = 12;
    localparam int SCALE_W  = 12;

    // Stream widths, padded to whole bytes
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_PAD_W   = OUT_TDATA_W - 2 * Q_W;

    // Configuration port
    localparam int CFG_INDEX_W = 2;

    typedef logic [SAMPLE_W-1:0]      sample_t;
    typedef logic signed [Q_W-1:0]    pressure_t;
    typedef logic [CFG_INDEX_W-1:0]   cfg_index_t;

    // Register indexes
    localparam cfg_index_t REG_WINDOW_LOW  = 2'd0;
    localparam cfg_index_t REG_WINDOW_HIGH = 2'd1;

    // Register reset values, signed Q4.8 bar
    localparam pressure_t WINDOW_LOW_RST  = 13'sd1024;
    localparam pressure_t WINDOW_HIGH_RST = 13'sd2560;

    // Count to pressure conversion: floor(total * 3203 / (1024 * depth)) - 320
    localparam logic [SCALE_W-1:0] SCALE_NUM = 12'd3203;
    localparam int                 FRAC_SHIFT = 10;
    localparam pressure_t          OFFSET_Q   = 13'sd320;

endpackage

[rtl/core/dpam_ram.sv]
// Generic single-clock RAM, one write port and one registered read port.
module dpam_ram #(
    parameter int WIDTH  = 10,
    parameter int DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read; a read of the address being written returns the old word
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/core/dpam_window.sv]
// Circular sample windows and running sums for both tanks.
module dpam_window #(
    parameter int DEPTH = 16,
    localparam int TOTAL_W = $clog2(((1 << dpam_pkg::SAMPLE_W) - 1) * DEPTH + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  dpam_pkg::sample_t     in_front,
    input  dpam_pkg::sample_t     in_rear,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [TOTAL_W-1:0]    total_front,
    output logic [TOTAL_W-1:0]    total_rear
);
    import dpam_pkg::*;

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic              accept;
    logic [ADDR_W-1:0] slot_reg, slot_next;
    logic              slot_last;
    logic              wrapped_reg, wrapped_next;

    logic              a_valid_reg;
    logic              a_ready;
    logic              a_move;
    logic              a_old_ok_reg;
    sample_t           a_front_reg;
    sample_t           a_rear_reg;
    sample_t           rd_front;
    sample_t           rd_rear;
    sample_t           old_front;
    sample_t           old_rear;

    logic               b_valid_reg;
    logic               b_ready;
    logic [TOTAL_W-1:0] total_front_reg, total_front_next;
    logic [TOTAL_W-1:0] total_rear_reg, total_rear_next;

    // Stage handshakes
    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign a_move   = a_valid_reg && b_ready;
    assign in_ready = a_ready;
    assign accept   = in_valid && a_ready;

    // Advance the write slot; flag the first wrap so unwritten entries read as zero
    assign slot_last    = (slot_reg == ADDR_W'(DEPTH - 1));
    assign slot_next    = slot_last ? '0 : slot_reg + ADDR_W'(1);
    assign wrapped_next = wrapped_reg || slot_last;

    // Window stores: write the new sample, read back the one it replaces
    dpam_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_ram_front (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (slot_reg),
        .wr_data (in_front),
        .rd_en   (accept),
        .rd_addr (slot_reg),
        .rd_data (rd_front)
    );

    dpam_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_ram_rear (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (slot_reg),
        .wr_data (in_rear),
        .rd_en   (accept),
        .rd_addr (slot_reg),
        .rd_data (rd_rear)
    );

    // Drop the departing sample from each running sum and add the new one
    assign old_front        = a_old_ok_reg ? rd_front : '0;
    assign old_rear         = a_old_ok_reg ? rd_rear : '0;
    assign total_front_next = total_front_reg - TOTAL_W'(old_front) + TOTAL_W'(a_front_reg);
    assign total_rear_next  = total_rear_reg - TOTAL_W'(old_rear) + TOTAL_W'(a_rear_reg);

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg        <= '0;
            wrapped_reg     <= 1'b0;
            a_valid_reg     <= 1'b0;
            b_valid_reg     <= 1'b0;
            total_front_reg <= '0;
            total_rear_reg  <= '0;
        end else begin
            if (accept) begin
                slot_reg    <= slot_next;
                wrapped_reg <= wrapped_next;
            end
            if (a_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            if (a_move) begin
                total_front_reg <= total_front_next;
                total_rear_reg  <= total_rear_next;
            end
        end
    end

    // Hold the request and the validity of its departing sample
    always_ff @(posedge aclk) begin
        if (accept) begin
            a_front_reg  <= in_front;
            a_rear_reg   <= in_rear;
            a_old_ok_reg <= wrapped_reg;
        end
    end

    assign out_valid   = b_valid_reg;
    assign total_front = total_front_reg;
    assign total_rear  = total_rear_reg;

endmodule

[rtl/core/dpam_scale.sv]
// Conversion of running sums to signed Q4.8 pressures and the window check.
module dpam_scale #(
    parameter int DEPTH = 16,
    localparam int TOTAL_W = $clog2(((1 << dpam_pkg::SAMPLE_W) - 1) * DEPTH + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [TOTAL_W-1:0]    total_front,
    input  logic [TOTAL_W-1:0]    total_rear,
    input  dpam_pkg::pressure_t   window_low,
    input  dpam_pkg::pressure_t   window_high,
    output logic                  out_valid,
    input  logic                  out_ready,
    output dpam_pkg::pressure_t   pressure_front,
    output dpam_pkg::pressure_t   pressure_rear,
    output logic                  tank_fault
);
    import dpam_pkg::*;

    // Product width, scaled width after the fixed shift, reciprocal of the depth
    localparam int PROD_W  = TOTAL_W + SCALE_W;
    localparam int SCL_W   = PROD_W - FRAC_SHIFT;
    localparam int DEPTH_B = (DEPTH > 1) ? $clog2(DEPTH) : 0;
    localparam int SHIFT   = SCL_W + DEPTH_B;
    localparam int MULT_W  = SHIFT + 1;
    localparam longint unsigned MULT = ((64'd1 << SHIFT) + DEPTH - 1) / DEPTH;
    localparam int QP_W    = SCL_W + MULT_W;

    logic              c_valid_reg, c_ready;
    logic [PROD_W-1:0] prod_front, prod_rear;
    logic [SCL_W-1:0]  c_front_reg, c_rear_reg;

    logic              d_valid_reg, d_ready;
    logic [QP_W-1:0]   qp_front, qp_rear;
    logic [QUOT_W-1:0] d_front_reg, d_rear_reg;

    logic              e_valid_reg, e_ready;
    pressure_t         press_front, press_rear;
    logic              fault_next;
    pressure_t         e_front_reg, e_rear_reg;
    logic              e_fault_reg;

    // Stage handshakes
    assign e_ready  = !e_valid_reg || out_ready;
    assign d_ready  = !d_valid_reg || e_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign in_ready = c_ready;

    // Scale by 3203 and drop the fixed 1024 divisor
    assign prod_front = PROD_W'(total_front) * PROD_W'(SCALE_NUM);
    assign prod_rear  = PROD_W'(total_rear) * PROD_W'(SCALE_NUM);

    // Divide by the depth through its rounded-up reciprocal
    assign qp_front = QP_W'(c_front_reg) * QP_W'(MULT_W'(MULT));
    assign qp_rear  = QP_W'(c_rear_reg) * QP_W'(MULT_W'(MULT));

    // Remove the sensor offset and compare against the healthy window
    assign press_front = Q_W'(d_front_reg) - OFFSET_Q;
    assign press_rear  = Q_W'(d_rear_reg) - OFFSET_Q;
    assign fault_next  = (press_front < window_low) || (press_front > window_high) ||
                         (press_rear < window_low) || (press_rear > window_high);

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end else begin
            if (c_ready) begin
                c_valid_reg <= in_valid;
            end
            if (d_ready) begin
                d_valid_reg <= c_valid_reg;
            end
            if (e_ready) begin
                e_valid_reg <= d_valid_reg;
            end
        end
    end

    // Payload stages
    always_ff @(posedge aclk) begin
        if (c_ready && in_valid) begin
            c_front_reg <= prod_front[PROD_W-1:FRAC_SHIFT];
            c_rear_reg  <= prod_rear[PROD_W-1:FRAC_SHIFT];
        end
        if (d_ready && c_valid_reg) begin
            d_front_reg <= qp_front[SHIFT +: QUOT_W];
            d_rear_reg  <= qp_rear[SHIFT +: QUOT_W];
        end
        if (e_ready && d_valid_reg) begin
            e_front_reg <= press_front;
            e_rear_reg  <= press_rear;
            e_fault_reg <= fault_next;
        end
    end

    assign out_valid      = e_valid_reg;
    assign pressure_front = e_front_reg;
    assign pressure_rear  = e_rear_reg;
    assign tank_fault     = e_fault_reg;

endmodule

[rtl/core/dual_pressure_average_monitor.sv]
// Top level of the dual tank pressure monitor: moving average and window check.
//
//  channel   direction  handshake                contents
//  s_        in         s_tvalid / s_tready      sample_front, sample_rear
//  m_        out        m_tvalid / m_tready      pressure_front, pressure_rear; fault
//  cfg_      in         cfg_valid / cfg_ready    register index, write data
//
// One sample pair is taken per cycle while s_tready is high; each request passes
// through the five register stages (window read, running sum, scale, depth divide,
// offset and compare).
// Reset clears the slot counter, the running sums and the fill flag; window entries
// not yet written since reset read as zero through that flag, so no clearing pass runs.
// Each stage holds its request while the next is full; s_tready falls only once all
// stages hold requests and m_tready is low. cfg_ready is always high.
module dual_pressure_average_monitor #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // sample_front [9:0], sample_rear [19:10], zero padding above
    input  logic [dpam_pkg::IN_TDATA_W-1:0]       s_tdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // pressure_front [12:0], pressure_rear [25:13], zero padding above
    output logic [dpam_pkg::OUT_TDATA_W-1:0]      m_tdata,
    // tank_fault [0]
    output logic                                  m_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  dpam_pkg::cfg_index_t                  cfg_index,
    input  dpam_pkg::pressure_t                   cfg_data
);
    import dpam_pkg::*;

    localparam int TOTAL_W = $clog2(((1 << SAMPLE_W) - 1) * WINDOW_DEPTH + 1);

    pressure_t          window_low_reg;
    pressure_t          window_high_reg;
    logic               sum_valid;
    logic               sum_ready;
    logic [TOTAL_W-1:0] total_front;
    logic [TOTAL_W-1:0] total_rear;
    pressure_t          pressure_front;
    pressure_t          pressure_rear;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_low_reg  <= WINDOW_LOW_RST;
            window_high_reg <= WINDOW_HIGH_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_WINDOW_LOW:  window_low_reg  <= cfg_data;
                REG_WINDOW_HIGH: window_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Windows and running sums
    dpam_window #(
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_front    (s_tdata[SAMPLE_W-1:0]),
        .in_rear     (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .out_valid   (sum_valid),
        .out_ready   (sum_ready),
        .total_front (total_front),
        .total_rear  (total_rear)
    );

    // Pressure conversion and window check
    dpam_scale #(
        .DEPTH (WINDOW_DEPTH)
    ) u_scale (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (sum_valid),
        .in_ready       (sum_ready),
        .total_front    (total_front),
        .total_rear     (total_rear),
        .window_low     (window_low_reg),
        .window_high    (window_high_reg),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .pressure_front (pressure_front),
        .pressure_rear  (pressure_rear),
        .tank_fault     (m_tuser)
    );

    // Pack the result
    assign m_tdata = {{OUT_PAD_W{1'b0}}, pressure_rear, pressure_front};

endmodule

[verif/dpam_stream_checker.sv]
`timescale 1ns / 1ps
// Checker for the dual tank pressure monitor: watches all channels, predicts and compares.
module dpam_stream_checker #(
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // sample_front [9:0], sample_rear [19:10], zero padding above
    input  logic [dpam_pkg::IN_TDATA_W-1:0]       s_tdata,
    input  logic                                  s_tvalid,
    input  logic                                  s_tready,
    // pressure_front [12:0], pressure_rear [25:13], zero padding above
    input  logic [dpam_pkg::OUT_TDATA_W-1:0]      m_tdata,
    // tank_fault [0]
    input  logic                                  m_tuser,
    input  logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic                                  cfg_valid,
    input  logic                                  cfg_ready,
    input  dpam_pkg::cfg_index_t                  cfg_index,
    input  dpam_pkg::pressure_t                   cfg_data,
    output int                                    mismatch_count,
    output int                                    results_pending
);
    import dpam_pkg::*;

    // Count to bar: floor(total * 3203 / (1024 * depth)) - 320
    localparam longint COUNT_TO_BAR = 3203;
    localparam int     BAR_OFFSET   = 320;
    localparam int     LOW_AT_RESET  = 1024;
    localparam int     HIGH_AT_RESET = 2560;
    localparam int     PRINT_CAP     = 40;

    typedef struct {
        pressure_t front;
        pressure_t rear;
        logic      fault;
    } reading_t;

    sample_t     front_hist [DEPTH];
    sample_t     rear_hist  [DEPTH];
    int          slot;
    int unsigned sum_front;
    int unsigned sum_rear;
    pressure_t   bound_low;
    pressure_t   bound_high;
    reading_t    expected_readings [$];
    int          results_seen;

    initial begin
        mismatch_count  = 0;
        results_pending = 0;
        results_seen    = 0;
    end

    task automatic note_mismatch(input string what);
        if (mismatch_count < PRINT_CAP)
            $display("MISMATCH at %0t, result %0d: %s", $realtime, results_seen, what);
        mismatch_count++;
    endtask

    function automatic int to_bar(input int unsigned total);
        longint scaled;
        scaled = (longint'(total) * COUNT_TO_BAR) / (longint'(1024) * DEPTH);
        return int'(scaled) - BAR_OFFSET;
    endfunction

    // Write one sample pair into the windows and work out the averaged reading
    function automatic reading_t advance_windows(input sample_t f, input sample_t r);
        reading_t res;
        int       pf;
        int       pr;
        sum_front = sum_front - front_hist[slot] + f;
        sum_rear  = sum_rear - rear_hist[slot] + r;
        front_hist[slot] = f;
        rear_hist[slot]  = r;
        slot = (slot + 1 >= DEPTH) ? 0 : slot + 1;
        pf = to_bar(sum_front);
        pr = to_bar(sum_rear);
        res.front = pressure_t'(pf);
        res.rear  = pressure_t'(pr);
        res.fault = (pf < int'(bound_low)) || (pf > int'(bound_high)) ||
                    (pr < int'(bound_low)) || (pr > int'(bound_high));
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        reading_t seen;
        reading_t want;
        int       delta;
        if (!aresetn) begin
            // clear the windows and restore the register defaults
            for (int i = 0; i < DEPTH; i++) begin
                front_hist[i] = '0;
                rear_hist[i]  = '0;
            end
            slot       = 0;
            sum_front  = 0;
            sum_rear   = 0;
            bound_low  = pressure_t'(LOW_AT_RESET);
            bound_high = pressure_t'(HIGH_AT_RESET);
            expected_readings.delete();
            results_pending <= 0;
        end else begin
            delta = 0;
            // register writes; unknown indexes leave everything alone
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_WINDOW_LOW:  bound_low  = cfg_data;
                    REG_WINDOW_HIGH: bound_high = cfg_data;
                    default: ;
                endcase
            end
            // compare a delivered result with the oldest expectation
            if (m_tvalid && m_tready) begin
                seen.front = m_tdata[Q_W-1:0];
                seen.rear  = m_tdata[2*Q_W-1:Q_W];
                seen.fault = m_tuser;
                if (expected_readings.size() == 0) begin
                    note_mismatch("result with nothing expected");
                end else begin
                    want = expected_readings.pop_front();
                    delta--;
                    if (seen.front !== want.front)
                        note_mismatch($sformatf("front pressure %0d, expected %0d",
                                                seen.front, want.front));
                    if (seen.rear !== want.rear)
                        note_mismatch($sformatf("rear pressure %0d, expected %0d",
                                                seen.rear, want.rear));
                    if (seen.fault !== want.fault)
                        note_mismatch($sformatf("tank fault %b, expected %b",
                                                seen.fault, want.fault));
                end
                if (m_tdata[OUT_TDATA_W-1:2*Q_W] !== '0)
                    note_mismatch("non-zero padding in result data");
                results_seen++;
            end
            // predict the result of an accepted request
            if (s_tvalid && s_tready) begin
                expected_readings.push_back(advance_windows(s_tdata[SAMPLE_W-1:0],
                                                            s_tdata[2*SAMPLE_W-1:SAMPLE_W]));
                delta++;
            end
            results_pending <= results_pending + delta;
        end
    end

endmodule

[verif/tb_dual_pressure_average_monitor.sv]
`timescale 1ns / 1ps
// Testbench top for the dual tank pressure monitor: stimulus, pressure and verdict.
module tb_dual_pressure_average_monitor;
    import dpam_pkg::*;

    localparam int DEPTH         = 16;
    localparam int IDLE_PCT      = 15;
    localparam int HOLD_OFF      = 64;
    localparam int DRAIN_CYCLES  = 8;
    localparam int QUIET_LIMIT   = 1000;
    localparam int PHASE_ITEMS   = 240;
    localparam int NUM_PHASES    = 8;
    localparam int SAMPLE_MAX    = 1023;

    // indexes beyond the register list
    localparam cfg_index_t REG_SPARE_A = 2'd2;
    localparam cfg_index_t REG_SPARE_B = 2'd3;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    cfg_index_t             cfg_index = '0;
    pressure_t              cfg_data  = '0;

    int mismatch_count;
    int results_pending;
    bit calm        = 1'b0;
    int hold_asked  = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int quiet       = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    dual_pressure_average_monitor #(
        .WINDOW_DEPTH (DEPTH)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dpam_stream_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tdata         (s_tdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    // Result side: random stalls, or a long hold-off when one is asked for
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_asked) begin
            hold_seen <= hold_asked;
            hold_left <= HOLD_OFF;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Abort when nothing moves on any channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic sample_t clamp_sample(input int v);
        if (v < 0)
            return '0;
        if (v > SAMPLE_MAX)
            return sample_t'(SAMPLE_MAX);
        return sample_t'(v);
    endfunction

    function automatic pressure_t bar_in_range();
        return pressure_t'(int'($urandom_range(0, 3200)) - 320);
    endfunction

    // Offer one sample pair, with random gaps ahead of it
    task automatic send_pair(input sample_t f, input sample_t r);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= {{(IN_TDATA_W - 2 * SAMPLE_W){1'b0}}, r, f};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input pressure_t value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Stop offering and wait until every expected result has come out
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_window(input pressure_t lo, input pressure_t hi);
        write_reg(REG_WINDOW_LOW, lo);
        write_reg(REG_WINDOW_HIGH, hi);
    endtask

    // Mostly steady levels with jitter so the averages settle and cross the
    // window bounds, mixed with rail values and plain noise
    task automatic run_random(input int count);
        int      left;
        int      kind;
        int      run_len;
        int      lf;
        int      lr;
        sample_t f;
        sample_t r;
        left = count;
        while (left > 0) begin
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                run_len = $urandom_range(4, 24);
                lf = $urandom_range(0, SAMPLE_MAX);
                lr = $urandom_range(0, SAMPLE_MAX);
                for (int i = 0; i < run_len && left > 0; i++) begin
                    f = clamp_sample(lf + int'($urandom_range(0, 16)) - 8);
                    r = clamp_sample(lr + int'($urandom_range(0, 16)) - 8);
                    send_pair(f, r);
                    left--;
                end
            end else if (kind < 8) begin
                f = $urandom_range(0, 1) ? sample_t'(SAMPLE_MAX) : '0;
                r = $urandom_range(0, 1) ? sample_t'(SAMPLE_MAX) : '0;
                send_pair(f, r);
                left--;
            end else begin
                send_pair(sample_t'($urandom_range(0, SAMPLE_MAX)),
                          sample_t'($urandom_range(0, SAMPLE_MAX)));
                left--;
            end
        end
    endtask

    initial begin
        pressure_t lo;
        pressure_t hi;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero windows under the reset bounds: lowest pressure, below the window
        send_pair('0, '0);
        settle();
        // both bounds inclusive at the lowest pressure
        set_window(-13'sd320, -13'sd320);
        send_pair('0, '0);
        // early averages still hold zeros, then fill the windows at full scale
        send_pair(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MAX));
        send_pair(sample_t'(SAMPLE_MAX), '0);
        send_pair('0, sample_t'(SAMPLE_MAX));
        repeat (DEPTH) send_pair(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MAX));
        settle();
        // both bounds inclusive at the highest pressure
        set_window(13'sd2879, 13'sd2879);
        send_pair(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MAX));
        settle();
        // just above the highest pressure; spare indexes must not move the bounds
        set_window(13'sd2880, 13'sd4095);
        write_reg(REG_SPARE_A, 13'sd2879);
        write_reg(REG_SPARE_B, 13'sd2879);
        send_pair(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MAX));

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            calm <= (ph == 0);
            case (ph)
                0: begin
                    lo = 13'sd1024;
                    hi = 13'sd2560;
                end
                1: begin
                    lo = bar_in_range();
                    hi = bar_in_range();
                    if (lo > hi) begin
                        lo = hi;
                        hi = bar_in_range();
                        if (hi < lo)
                            hi = 13'sd2880;
                    end
                end
                2: begin
                    lo = -13'sd4096;
                    hi = 13'sd4095;
                end
                3: begin
                    // inverted window: every reading is a fault
                    lo = 13'sd2880;
                    hi = -13'sd320;
                end
                4: begin
                    lo = bar_in_range();
                    hi = lo;
                end
                6: begin
                    lo = pressure_t'($urandom_range(0, 8191));
                    hi = pressure_t'($urandom_range(0, 8191));
                end
                7: begin
                    lo = -13'sd320;
                    hi = 13'sd2880;
                end
                default: begin
                    lo = 13'sd256;
                    hi = 13'sd1800;
                end
            endcase
            set_window(lo, hi);
            if (ph == 5) begin
                // hold the result side off while requests keep coming
                hold_asked <= hold_asked + 1;
                run_random(PHASE_ITEMS / 2);
                hold_asked <= hold_asked + 1;
                run_random(PHASE_ITEMS / 2);
            end else begin
                run_random(PHASE_ITEMS);
            end
        end

        settle();
        if (mismatch_count == 0 && results_pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
